// ===== rtl/core/dcipc_pkg.sv =====
// shared types and constants for the dual cpu mailbox fifo
package dcipc_pkg;

    localparam logic [1:0] ACT_BYTE_RD = 2'd0;
    localparam logic [1:0] ACT_BYTE_WR = 2'd1;
    localparam logic [1:0] ACT_WORD_RD = 2'd2;
    localparam logic [1:0] ACT_WORD_WR = 2'd3;

    localparam logic [2:0] SEL_SYNC_LO   = 3'd0;
    localparam logic [2:0] SEL_SYNC_HI   = 3'd1;
    localparam logic [2:0] SEL_CTRL_LO   = 3'd2;
    localparam logic [2:0] SEL_CTRL_HI   = 3'd3;
    localparam logic [2:0] SEL_SEND_FIFO = 3'd4;
    localparam logic [2:0] SEL_RECV_FIFO = 3'd5;

    localparam logic [7:0] SYNC_LO_MASK = 8'h0F;
    localparam logic [7:0] SYNC_HI_MASK = 8'h4F;

    localparam int IRQ_SYNC_BIT  = 0;
    localparam int IRQ_EMPTY_BIT = 1;
    localparam int IRQ_RECV_BIT  = 2;

    typedef struct packed {
        logic load;
        logic exec;
        logic resp;
    } cmd_t;

endpackage

// ===== rtl/core/dcipc_ctrl.sv =====
// controller state machine sequencing one bus request at a time
module dcipc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output dcipc_pkg::cmd_t   cmd
);
    import dcipc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   exec_reg;
    logic   exec_next;
    logic   resp_reg;
    logic   resp_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_RESP;
            ST_RESP: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        busy_next = (state_next != ST_IDLE);
        exec_next = (state_next == ST_EXEC);
        resp_next = (state_next == ST_RESP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            exec_reg  <= 1'b0;
            resp_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            exec_reg  <= exec_next;
            resp_reg  <= resp_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = resp_reg;
    assign cmd.load = start && (state_reg == ST_IDLE);
    assign cmd.exec = exec_reg;
    assign cmd.resp = resp_reg;

endmodule

// ===== rtl/core/dcipc_datapath.sv =====
// mailbox registers, send fifo storage and request decode
module dcipc_datapath #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dcipc_pkg::cmd_t   cmd,
    input  logic [1:0]        action,
    input  logic              side,
    input  logic [2:0]        reg_select,
    input  logic [31:0]       write_data,
    output logic [31:0]       read_data,
    output logic [2:0]        irq_first_cpu,
    output logic [2:0]        irq_second_cpu,
    output logic              unmapped
);
    import dcipc_pkg::*;

    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int MEM_DEPTH = 2 * (2 ** PTR_W);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
        next_slot = (ptr == LAST_PTR) ? '0 : ptr + 1'b1;
    endfunction

    // latched request
    logic [1:0]  action_reg;
    logic        side_reg;
    logic [2:0]  sel_reg;
    logic [31:0] wdata_reg;

    // per side state
    logic [7:0]       sync_reg    [2];
    logic [CNT_W-1:0] count_reg   [2];
    logic [PTR_W-1:0] head_reg    [2];
    logic [PTR_W-1:0] tail_reg    [2];
    logic [31:0]      popped_reg  [2];
    logic [1:0]       empty_en_reg;
    logic [1:0]       recv_en_reg;
    logic [1:0]       error_reg;
    logic [1:0]       fifo_en_reg;

    logic [31:0] fifo_mem [MEM_DEPTH];
    logic [31:0] mem_rdata_reg;

    // response
    logic [31:0] rdata_reg;
    logic [2:0]  irq0_reg;
    logic [2:0]  irq1_reg;
    logic        unmapped_reg;
    logic        pop_reg;

    logic             s;
    logic             p;
    logic [7:0]       b;
    logic [7:0]       rd_byte;
    logic [31:0]      rd_c;
    logic [2:0]       irq_own;
    logic [2:0]       irq_partner;
    logic             hit_c;
    logic             own_full;
    logic             own_empty;
    logic             partner_full;
    logic             partner_empty;
    logic             do_push;
    logic             do_pop;
    logic             clear_own;
    logic [CNT_W-1:0] own_cnt_after;

    assign s             = side_reg;
    assign p             = ~side_reg;
    assign b             = wdata_reg[7:0];
    assign own_full      = (count_reg[s] == FULL_CNT);
    assign own_empty     = (count_reg[s] == '0);
    assign partner_full  = (count_reg[p] == FULL_CNT);
    assign partner_empty = (count_reg[p] == '0);
    assign clear_own     = (action_reg == ACT_BYTE_WR) && (sel_reg == SEL_CTRL_LO) && b[3];
    assign own_cnt_after = clear_own ? '0 : count_reg[s];

    always_comb
    begin
        rd_byte     = 8'd0;
        rd_c        = 32'd0;
        irq_own     = 3'd0;
        irq_partner = 3'd0;
        hit_c       = 1'b1;
        do_push     = 1'b0;
        do_pop      = 1'b0;
        case (action_reg)
            ACT_BYTE_RD:
            begin
                case (sel_reg)
                    SEL_SYNC_LO: rd_byte = sync_reg[p] & SYNC_LO_MASK;
                    SEL_SYNC_HI: rd_byte = sync_reg[s] & SYNC_HI_MASK;
                    SEL_CTRL_LO: rd_byte = {5'd0, empty_en_reg[s], own_full, own_empty};
                    SEL_CTRL_HI: rd_byte = {fifo_en_reg[s], error_reg[s], 3'd0,
                                            recv_en_reg[s], partner_full, partner_empty};
                    default:     hit_c   = 1'b0;
                endcase
                rd_c = {24'd0, rd_byte};
            end
            ACT_BYTE_WR:
            begin
                case (sel_reg)
                    SEL_SYNC_LO: ;
                    SEL_SYNC_HI:
                        irq_partner[IRQ_SYNC_BIT] = b[5] && sync_reg[p][6];
                    SEL_CTRL_LO:
                        irq_own[IRQ_EMPTY_BIT] = !empty_en_reg[s] && b[2]
                                                 && (own_cnt_after == '0);
                    SEL_CTRL_HI:
                        irq_own[IRQ_RECV_BIT] = !recv_en_reg[s] && b[2] && !partner_empty;
                    default: hit_c = 1'b0;
                endcase
            end
            ACT_WORD_RD:
            begin
                if (sel_reg == SEL_RECV_FIFO)
                begin
                    do_pop = !partner_empty;
                    irq_partner[IRQ_EMPTY_BIT] = (count_reg[p] == CNT_W'(1))
                                                 && empty_en_reg[p] && fifo_en_reg[p];
                    rd_c = popped_reg[p];
                end
                else
                begin
                    hit_c = 1'b0;
                end
            end
            ACT_WORD_WR:
            begin
                if (sel_reg == SEL_SEND_FIFO)
                begin
                    do_push = !own_full;
                    irq_partner[IRQ_RECV_BIT] = own_empty && recv_en_reg[p] && fifo_en_reg[s];
                end
                else
                begin
                    hit_c = 1'b0;
                end
            end
            default: hit_c = 1'b0;
        endcase
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            side_reg   <= side;
            sel_reg    <= reg_select;
            wdata_reg  <= write_data;
        end
        if (cmd.exec)
        begin
            rdata_reg    <= rd_c;
            irq0_reg     <= s ? irq_partner : irq_own;
            irq1_reg     <= s ? irq_own : irq_partner;
            unmapped_reg <= !hit_c;
            pop_reg      <= do_pop;
        end
    end

    // fifo storage
    always_ff @(posedge clk)
    begin
        if (cmd.exec && do_push)
        begin
            fifo_mem[{s, tail_reg[s]}] <= wdata_reg;
        end
        if (cmd.exec)
        begin
            mem_rdata_reg <= fifo_mem[{p, head_reg[p]}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                sync_reg[i]   <= 8'd0;
                count_reg[i]  <= '0;
                head_reg[i]   <= '0;
                tail_reg[i]   <= '0;
                popped_reg[i] <= 32'd0;
            end
            empty_en_reg <= 2'b00;
            recv_en_reg  <= 2'b00;
            error_reg    <= 2'b00;
            fifo_en_reg  <= 2'b00;
        end
        else
        begin
            if (cmd.resp && pop_reg)
            begin
                popped_reg[~side_reg] <= mem_rdata_reg;
            end
            if (cmd.exec)
            begin
                case (action_reg)
                    ACT_BYTE_WR:
                    begin
                        case (sel_reg)
                            SEL_SYNC_HI: sync_reg[s] <= b;
                            SEL_CTRL_LO:
                            begin
                                empty_en_reg[s] <= b[2];
                                if (b[3])
                                begin
                                    count_reg[s] <= '0;
                                    head_reg[s]  <= '0;
                                    tail_reg[s]  <= '0;
                                end
                            end
                            SEL_CTRL_HI:
                            begin
                                recv_en_reg[s] <= b[2];
                                fifo_en_reg[s] <= b[7];
                                if (b[6])
                                begin
                                    error_reg[s] <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                    ACT_WORD_RD:
                    begin
                        if (sel_reg == SEL_RECV_FIFO)
                        begin
                            if (partner_empty)
                            begin
                                error_reg[s] <= 1'b1;
                            end
                            else
                            begin
                                head_reg[p]  <= next_slot(head_reg[p]);
                                count_reg[p] <= count_reg[p] - 1'b1;
                            end
                        end
                    end
                    ACT_WORD_WR:
                    begin
                        if (sel_reg == SEL_SEND_FIFO)
                        begin
                            if (own_full)
                            begin
                                error_reg[s] <= 1'b1;
                            end
                            else
                            begin
                                tail_reg[s]  <= next_slot(tail_reg[s]);
                                count_reg[s] <= count_reg[s] + 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign read_data      = cmd.resp ? (pop_reg ? mem_rdata_reg : rdata_reg) : 32'd0;
    assign irq_first_cpu  = cmd.resp ? irq0_reg : 3'd0;
    assign irq_second_cpu = cmd.resp ? irq1_reg : 3'd0;
    assign unmapped       = cmd.resp ? unmapped_reg : 1'b0;

endmodule

// ===== rtl/core/dual_cpu_ipc_sync_fifo_top.sv =====
// top level of the dual cpu mailbox fifo
// a taken request goes through states exec then resp; done and its result show in resp
// a new request is taken only back in idle, after the done cycle ends
// busy stays high from the accepting edge until the done cycle ends; done lasts one cycle
// reset: rst_n clears all flags, counts, pointers and sync bytes; fifo storage is not cleared
module dual_cpu_ipc_sync_fifo_top #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [1:0]  action,
    input  logic        side,
    input  logic [2:0]  reg_select,
    input  logic [31:0] write_data,
    output logic [31:0] read_data,
    output logic [2:0]  irq_first_cpu,
    output logic [2:0]  irq_second_cpu,
    output logic        unmapped
);
    import dcipc_pkg::*;

    cmd_t cmd;

    dcipc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    dcipc_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .action         (action),
        .side           (side),
        .reg_select     (reg_select),
        .write_data     (write_data),
        .read_data      (read_data),
        .irq_first_cpu  (irq_first_cpu),
        .irq_second_cpu (irq_second_cpu),
        .unmapped       (unmapped)
    );

    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy && !done)
        else $error("accepted request did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy && $past(busy))
        else $error("done without a request in flight");

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done && !busy)
        else $error("done held for more than one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (read_data == 32'd0) && (irq_first_cpu == 3'd0)
                  && (irq_second_cpu == 3'd0) && !unmapped)
        else $error("result outputs active outside done");

endmodule
